### hdl/assert_macros.svh
// assertion macros included by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lbm_pkg.sv
// package: widths, register indexes and fixed-point helpers for the collision node
package lbm_pkg;

    localparam int WordW       = 32;
    localparam int NumDir      = 9;
    localparam int DefFracBits = 24;
    localparam int PipeDepth   = 8;

    typedef logic signed [WordW-1:0] word_t;
    typedef word_t dir_vec_t [NumDir];

    typedef enum logic [2:0] {
        REG_RELAX_SYM  = 3'd0,
        REG_RELAX_ANTI = 3'd1,
        REG_SPEED      = 3'd2,
        REG_INV_SPEED  = 3'd3,
        REG_REF_DENS   = 3'd4,
        REG_INV_REF    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        word_t relax_sym;
        word_t relax_anti;
        word_t speed;
        word_t inv_speed;
        word_t ref_density;
        word_t inv_ref_density;
    } cfg_t;

    function automatic word_t sat64(input logic signed [63:0] v);
        word_t r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[WordW-1:0];
        return r;
    endfunction

    // opposite direction of each lane
    function automatic int unsigned opp(input int unsigned k);
        int unsigned r;
        case (k)
            1: r = 3;
            2: r = 4;
            3: r = 1;
            4: r = 2;
            5: r = 7;
            6: r = 8;
            7: r = 5;
            8: r = 6;
            default: r = 0;
        endcase
        return r;
    endfunction

    function automatic int dx(input int unsigned k);
        int r;
        case (k)
            1, 5, 8: r = 1;
            3, 6, 7: r = -1;
            default: r = 0;
        endcase
        return r;
    endfunction

    function automatic int dy(input int unsigned k);
        int r;
        case (k)
            2, 5, 6: r = 1;
            4, 7, 8: r = -1;
            default: r = 0;
        endcase
        return r;
    endfunction

endpackage

### hdl/lbm_fmul.sv
// registered fixed-point multiply with rounding and saturation
module lbm_fmul #(
    parameter int FRAC_BITS = lbm_pkg::DefFracBits
) (
    input  logic          clk,
    input  lbm_pkg::word_t a,
    input  lbm_pkg::word_t b,
    output lbm_pkg::word_t p
);
    import lbm_pkg::*;

    localparam logic signed [63:0] Half = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] prod;
    word_t p_reg;
    word_t p_next;

    always_comb
    begin
        prod   = 64'(a) * 64'(b) + Half;
        p_next = sat64(prod >>> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;
endmodule

### hdl/lbm_lane.sv
// one direction lane: equilibrium from the shared velocity terms
module lbm_lane #(
    parameter int FRAC_BITS = lbm_pkg::DefFracBits,
    parameter int DIR_X     = 0,
    parameter int DIR_Y     = 0,
    parameter int W_NUM     = 1,
    parameter int W_DEN     = 9
) (
    input  logic           clk,
    input  lbm_pkg::word_t ux,
    input  lbm_pkg::word_t uy,
    input  lbm_pkg::word_t usq,
    input  lbm_pkg::word_t rho,
    input  lbm_pkg::word_t ref_density,
    output lbm_pkg::word_t feq
);
    import lbm_pkg::*;

    localparam logic signed [63:0] DenTwo = 64'(2 * W_DEN);
    localparam logic signed [63:0] NumTwo = 64'(2 * W_NUM);
    localparam int PreShift = $clog2((2 * W_DEN) / 9);
    localparam logic [34:0] Bias = 35'(64'sd9 <<< 30);
    localparam logic [17:0] RecipHi = 18'd233017;
    localparam logic [22:0] RecipLo = 23'd7456541;
    localparam logic signed [35:0] QBias = 36'sd1 <<< 30;

    word_t eu_reg, eu_next, usq_d_reg, rho_d1_reg, rho_d2_reg, rho_d3_reg;
    word_t sq;
    word_t poly_reg, poly_next, eu_d2_reg;
    word_t mp;
    word_t feq_reg, feq_next;
    logic signed [63:0] num;
    logic [34:0] ub;
    logic [16:0] uh;
    logic [34:0] qh_prod;
    logic [13:0] qh_next, qh_reg;
    logic [3:0] rh;
    logic [21:0] lo_next, lo_reg;
    logic [44:0] ql_prod;
    logic [18:0] ql;
    logic signed [35:0] quo;

    always_comb
    begin
        eu_next = sat64(64'(DIR_X) * 64'(ux) + 64'(DIR_Y) * 64'(uy));
    end

    lbm_fmul #(.FRAC_BITS(FRAC_BITS)) u_sq (.clk(clk), .a(eu_reg), .b(eu_reg), .p(sq));

    always_comb
    begin
        poly_next = sat64((64'sd6 * 64'(eu_d2_reg) + 64'sd9 * 64'(sq)
                          - 64'sd3 * 64'(usq_d_reg) + 64'sd1) >>> 1);
    end

    lbm_fmul #(.FRAC_BITS(FRAC_BITS)) u_rp (.clk(clk), .a(ref_density), .b(poly_reg),
                                            .p(mp));

    // divide by nine over two stages: biased to non-negative, high part then low part
    always_comb
    begin
        num     = (NumTwo * 64'(sat64(64'(rho_d3_reg) + 64'(mp))) + DenTwo / 2) >>> PreShift;
        ub      = 35'(num) + Bias;
        uh      = ub[34:18];
        qh_prod = 35'(uh) * 35'(RecipHi);
        qh_next = qh_prod[34:21];
        rh      = 4'(uh - 17'(qh_next) * 17'd9);
        lo_next = {rh, ub[17:0]};
    end

    always_comb
    begin
        ql_prod  = 45'(lo_reg) * 45'(RecipLo);
        ql       = ql_prod[44:26];
        quo      = $signed({4'd0, qh_reg, 18'd0}) + $signed({17'd0, ql}) - QBias;
        feq_next = quo[WordW-1:0];
    end

    always_ff @(posedge clk)
    begin
        eu_reg     <= eu_next;
        usq_d_reg  <= usq;
        eu_d2_reg  <= eu_reg;
        poly_reg   <= poly_next;
        rho_d1_reg <= rho;
        rho_d2_reg <= rho_d1_reg;
        rho_d3_reg <= rho_d2_reg;
        qh_reg     <= qh_next;
        lo_reg     <= lo_next;
        feq_reg    <= feq_next;
    end

    assign feq = feq_reg;
endmodule

### hdl/lattice_boltzmann_d2q9_trt_node.sv
// top level: D2Q9 two-relaxation-time collision for one node per cycle
//  channel   | handshake          | payload
//  config    | cfg_we             | cfg_index, cfg_data
//  item in   | start, busy        | dist_0 .. dist_8
//  item out  | done               | post_0 .. post_8, density, velocity_x/y
// one item per cycle; results leave in start order, each flagged by done
// the pipe runs through six chained registered multiplies plus moment, divide and merge stages
// busy is always low: no stall; the receiver takes done whenever it is high
// reset clears the valid pipe and loads the default relaxation rates
module lattice_boltzmann_d2q9_trt_node #(
    parameter int FRAC_BITS = lbm_pkg::DefFracBits
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  lbm_pkg::word_t cfg_data,
    input  logic           start,
    output logic           busy,
    input  lbm_pkg::word_t dist_0, dist_1, dist_2, dist_3, dist_4,
    input  lbm_pkg::word_t dist_5, dist_6, dist_7, dist_8,
    output logic           done,
    output lbm_pkg::word_t post_0, post_1, post_2, post_3, post_4,
    output lbm_pkg::word_t post_5, post_6, post_7, post_8,
    output lbm_pkg::word_t density,
    output lbm_pkg::word_t velocity_x,
    output lbm_pkg::word_t velocity_y
);
    import lbm_pkg::*;

    localparam int Lat = 14;
    localparam logic signed [63:0] One = 64'sd1 <<< FRAC_BITS;

    cfg_t cfg_reg;
    logic [Lat-1:0] vld_reg;
    dir_vec_t f_in;
    dir_vec_t f_pipe_reg [Lat];
    word_t rho_pipe_reg [Lat];

    word_t rho_next, mx_next, my_next;
    word_t mx_reg, my_reg;
    word_t sx, sy, vx, vy, ux, uy, uxx, uyy;
    word_t usq_reg;
    word_t vx_pipe_reg [Lat];
    word_t vy_pipe_reg [Lat];
    dir_vec_t feq;
    word_t neq_sat [NumDir];
    word_t sh_reg [NumDir];
    word_t ah_reg [NumDir];
    word_t ms [NumDir];
    word_t ma [NumDir];
    word_t post_reg [NumDir];
    logic signed [33:0] neq [NumDir];

    assign f_in = '{dist_0, dist_1, dist_2, dist_3, dist_4, dist_5, dist_6, dist_7, dist_8};
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.relax_sym       <= word_t'(-One);
            cfg_reg.relax_anti      <= word_t'(-(((64'sd16 * One + 64'sd7) / 64'sd14)));
            cfg_reg.speed           <= word_t'(One);
            cfg_reg.inv_speed       <= word_t'(One);
            cfg_reg.ref_density     <= word_t'(One);
            cfg_reg.inv_ref_density <= word_t'(One);
            vld_reg                 <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[Lat-2:0], start};
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RELAX_SYM:  cfg_reg.relax_sym       <= cfg_data;
                    REG_RELAX_ANTI: cfg_reg.relax_anti      <= cfg_data;
                    REG_SPEED:      cfg_reg.speed           <= cfg_data;
                    REG_INV_SPEED:  cfg_reg.inv_speed       <= cfg_data;
                    REG_REF_DENS:   cfg_reg.ref_density     <= cfg_data;
                    REG_INV_REF:    cfg_reg.inv_ref_density <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // moments
    always_comb
    begin
        logic signed [63:0] s, x, y;
        s = '0;
        x = '0;
        y = '0;
        for (int k = 0; k < NumDir; k++)
        begin
            s = s + 64'(f_in[k]);
            x = x + 64'(dx(k)) * 64'(f_in[k]);
            y = y + 64'(dy(k)) * 64'(f_in[k]);
        end
        rho_next = sat64(s);
        mx_next  = sat64(x);
        my_next  = sat64(y);
    end

    always_ff @(posedge clk)
    begin
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        f_pipe_reg[0]   <= f_in;
        rho_pipe_reg[0] <= rho_next;
        for (int i = 1; i < Lat; i++)
        begin
            f_pipe_reg[i]   <= f_pipe_reg[i-1];
            rho_pipe_reg[i] <= rho_pipe_reg[i-1];
        end
    end

    // stage 1 -> 2: speed * m
    lbm_fmul #(.FRAC_BITS(FRAC_BITS)) u_sx (.clk(clk), .a(cfg_reg.speed), .b(mx_reg), .p(sx));
    lbm_fmul #(.FRAC_BITS(FRAC_BITS)) u_sy (.clk(clk), .a(cfg_reg.speed), .b(my_reg), .p(sy));
    // 2 -> 3: velocity
    lbm_fmul #(.FRAC_BITS(FRAC_BITS)) u_vx (.clk(clk), .a(sx), .b(cfg_reg.inv_ref_density),
                                            .p(vx));
    lbm_fmul #(.FRAC_BITS(FRAC_BITS)) u_vy (.clk(clk), .a(sy), .b(cfg_reg.inv_ref_density),
                                            .p(vy));
    // 3 -> 4: scaled velocity
    lbm_fmul #(.FRAC_BITS(FRAC_BITS)) u_ux (.clk(clk), .a(vx), .b(cfg_reg.inv_speed), .p(ux));
    lbm_fmul #(.FRAC_BITS(FRAC_BITS)) u_uy (.clk(clk), .a(vy), .b(cfg_reg.inv_speed), .p(uy));
    // 4 -> 5: squares
    lbm_fmul #(.FRAC_BITS(FRAC_BITS)) u_xx (.clk(clk), .a(ux), .b(ux), .p(uxx));
    lbm_fmul #(.FRAC_BITS(FRAC_BITS)) u_yy (.clk(clk), .a(uy), .b(uy), .p(uyy));

    word_t ux_d_reg, uy_d_reg;

    always_ff @(posedge clk)
    begin
        ux_d_reg <= ux;
        uy_d_reg <= uy;
        usq_reg  <= sat64(64'(uxx) + 64'(uyy));
        vx_pipe_reg[0] <= vx;
        vy_pipe_reg[0] <= vy;
        for (int i = 1; i < Lat; i++)
        begin
            vx_pipe_reg[i] <= vx_pipe_reg[i-1];
            vy_pipe_reg[i] <= vy_pipe_reg[i-1];
        end
    end

    // lanes: each lane registers its ux_d product so it meets usq at stage 6; rho taken from the delay line
    for (genvar k = 0; k < NumDir; k++)
    begin : g_lane
        lbm_lane #(
            .FRAC_BITS(FRAC_BITS),
            .DIR_X(dx(k)),
            .DIR_Y(dy(k)),
            .W_NUM(k == 0 ? 4 : 1),
            .W_DEN(k == 0 ? 9 : (k < 5 ? 9 : 36))
        ) u_lane (
            .clk(clk),
            .ux(ux_d_reg),
            .uy(uy_d_reg),
            .usq(usq_reg),
            .rho(rho_pipe_reg[5]),
            .ref_density(cfg_reg.ref_density),
            .feq(feq[k])
        );
    end

    // merge: pair opposite lanes (feq valid at stage 11)
    always_comb
    begin
        for (int k = 0; k < NumDir; k++)
        begin
            neq[k]     = 34'(f_pipe_reg[10][k]) - 34'(feq[k]);
            neq_sat[k] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NumDir; k++)
        begin
            sh_reg[k] <= sat64((64'(neq[k]) + 64'(neq[opp(k)]) + 64'sd1) >>> 1);
            ah_reg[k] <= sat64((64'(neq[k]) - 64'(neq[opp(k)]) + 64'sd1) >>> 1);
        end
    end

    for (genvar k = 0; k < NumDir; k++)
    begin : g_relax
        lbm_fmul #(.FRAC_BITS(FRAC_BITS)) u_ms (.clk(clk), .a(cfg_reg.relax_sym),
                                                .b(sh_reg[k]), .p(ms[k]));
        lbm_fmul #(.FRAC_BITS(FRAC_BITS)) u_ma (.clk(clk), .a(cfg_reg.relax_anti),
                                                .b(ah_reg[k]), .p(ma[k]));
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NumDir; k++)
            post_reg[k] <= sat64(64'(f_pipe_reg[12][k]) + 64'(ms[k]) + 64'(ma[k])
                                 + 64'(neq_sat[k]));
    end

    assign done       = vld_reg[Lat-1];
    assign post_0     = post_reg[0];
    assign post_1     = post_reg[1];
    assign post_2     = post_reg[2];
    assign post_3     = post_reg[3];
    assign post_4     = post_reg[4];
    assign post_5     = post_reg[5];
    assign post_6     = post_reg[6];
    assign post_7     = post_reg[7];
    assign post_8     = post_reg[8];
    assign density    = rho_pipe_reg[Lat-1];
    assign velocity_x = vx_pipe_reg[Lat-4];
    assign velocity_y = vy_pipe_reg[Lat-4];
endmodule

### hdl/lbm_checker.sv
// port checker for the collision node and its bind
`include "assert_macros.svh"

module lbm_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    logic [13:0] hist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hist_reg <= '0;
        else
            hist_reg <= {hist_reg[12:0], start && !busy};
    end

    `ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy, "busy raised")
    `ASSERT_IMPL(a_done_matches, clk, rst_n, 1'b1, done == hist_reg[13], "done without item")
    `ASSERT_NEXT(a_fill, clk, rst_n, start, hist_reg[0], "item not tracked")
endmodule

bind lattice_boltzmann_d2q9_trt_node lbm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done)
);

### bench/tb.sv
// testbench for the d2q9 two-relaxation-time collision node: directed table and random nodes under several settings
`timescale 1ns / 100ps

module tb;
    import lbm_pkg::*;

    typedef logic [8:0][31:0]  node_in_t;
    typedef logic [11:0][31:0] node_out_t;

    localparam int        FRAC    = 24;
    localparam int        LATENCY = 14;
    localparam logic [2:0] BAD_IDX_LO = 3'd6;
    localparam logic [2:0] BAD_IDX_HI = 3'd7;
    localparam int        DIR_X [9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int        DIR_Y [9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    localparam int        OPP [9]   = '{0, 3, 4, 1, 2, 7, 8, 5, 6};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    word_t cfg_data = '0;
    logic start = 1'b0;
    logic busy, done;
    node_in_t node_in = '0;
    word_t post_0, post_1, post_2, post_3, post_4, post_5, post_6, post_7, post_8;
    word_t density, velocity_x, velocity_y;

    longint relax_sym, relax_anti, speed, inv_speed, ref_dens, inv_ref;
    node_out_t expected_q[$];
    int errors = 0;
    int nodes_sent = 0;
    int nodes_checked = 0;
    int phases = 0;

    always #10 clk = ~clk;

    lattice_boltzmann_d2q9_trt_node dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy),
        .dist_0(node_in[0]), .dist_1(node_in[1]), .dist_2(node_in[2]),
        .dist_3(node_in[3]), .dist_4(node_in[4]), .dist_5(node_in[5]),
        .dist_6(node_in[6]), .dist_7(node_in[7]), .dist_8(node_in[8]),
        .done(done), .post_0(post_0), .post_1(post_1), .post_2(post_2),
        .post_3(post_3), .post_4(post_4), .post_5(post_5), .post_6(post_6),
        .post_7(post_7), .post_8(post_8), .density(density),
        .velocity_x(velocity_x), .velocity_y(velocity_y)
    );

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return clamp32((a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
    endfunction

    function automatic longint div_floor(input longint v, input longint d);
        if (v >= 0)
            return v / d;
        return -((-v - 1) / d) - 1;
    endfunction

    function automatic node_out_t collide(input node_in_t d);
        longint f [9];
        longint neq [9];
        longint sum, mx, my, rho, vx, vy, ux, uy, usq, eu, sq, poly, x, sh, ah, wn, wd;
        node_out_t r;
        sum = 0;
        mx = 0;
        my = 0;
        for (int k = 0; k < 9; k++)
        begin
            f[k] = longint'($signed(d[k]));
            sum += f[k];
            mx += DIR_X[k] * f[k];
            my += DIR_Y[k] * f[k];
        end
        rho = clamp32(sum);
        vx = qmul(qmul(speed, clamp32(mx)), inv_ref);
        vy = qmul(qmul(speed, clamp32(my)), inv_ref);
        ux = qmul(vx, inv_speed);
        uy = qmul(vy, inv_speed);
        usq = clamp32(qmul(ux, ux) + qmul(uy, uy));
        for (int k = 0; k < 9; k++)
        begin
            eu = clamp32(DIR_X[k] * ux + DIR_Y[k] * uy);
            sq = qmul(eu, eu);
            poly = clamp32((6 * eu + 9 * sq - 3 * usq + 1) >>> 1);
            x = clamp32(rho + qmul(ref_dens, poly));
            wn = (k == 0) ? 4 : 1;
            wd = (k < 5) ? 9 : 36;
            neq[k] = f[k] - div_floor(2 * x * wn + wd, 2 * wd);
        end
        for (int k = 0; k < 9; k++)
        begin
            sh = clamp32((neq[k] + neq[OPP[k]] + 1) >>> 1);
            ah = clamp32((neq[k] - neq[OPP[k]] + 1) >>> 1);
            r[k] = 32'(clamp32(f[k] + qmul(relax_sym, sh) + qmul(relax_anti, ah)));
        end
        r[9] = 32'(rho);
        r[10] = 32'(vx);
        r[11] = 32'(vy);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        node_out_t got;
        node_out_t want;
        if (rst_n && done)
        begin
            got = {velocity_y, velocity_x, density, post_8, post_7, post_6, post_5,
                   post_4, post_3, post_2, post_1, post_0};
            if (expected_q.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = expected_q.pop_front();
                nodes_checked++;
                for (int k = 0; k < 12; k++)
                    if (got[k] !== want[k])
                        report_mismatch($sformatf("field %0d got %h want %h",
                                                  k, got[k], want[k]));
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input longint value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[31:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RELAX_SYM:  relax_sym  = longint'($signed(value[31:0]));
            REG_RELAX_ANTI: relax_anti = longint'($signed(value[31:0]));
            REG_SPEED:      speed      = longint'($signed(value[31:0]));
            REG_INV_SPEED:  inv_speed  = longint'($signed(value[31:0]));
            REG_REF_DENS:   ref_dens   = longint'($signed(value[31:0]));
            REG_INV_REF:    inv_ref    = longint'($signed(value[31:0]));
            default: ;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (LATENCY + 6) @(negedge clk);
    endtask

    task automatic configure(input longint rs, input longint ra, input longint sp,
                             input longint isp, input longint rd, input longint ird);
        drain();
        write_reg(REG_RELAX_SYM, rs);
        write_reg(REG_RELAX_ANTI, ra);
        write_reg(REG_SPEED, sp);
        write_reg(REG_INV_SPEED, isp);
        write_reg(REG_REF_DENS, rd);
        write_reg(REG_INV_REF, ird);
        write_reg(BAD_IDX_LO, $urandom());
        write_reg(BAD_IDX_HI, $urandom());
        phases++;
    endtask

    task automatic send_node(input node_in_t d, input bit typed, input node_out_t want);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        node_in <= d;
        do
            @(posedge clk);
        while (busy);
        expected_q.push_back(typed ? want : collide(d));
        nodes_sent++;
        @(negedge clk);
    endtask

    function automatic node_in_t random_node();
        node_in_t d;
        int mode;
        longint base, w;
        mode = $urandom_range(0, 9);
        base = (64'sd1 <<< FRAC) + $signed($urandom_range(0, 1 << 23)) - (1 << 22);
        for (int k = 0; k < 9; k++)
        begin
            w = (k == 0) ? base * 4 / 9 : (k < 5 ? base / 9 : base / 36);
            case (mode)
                6, 7:    d[k] = $urandom();
                8:       case ($urandom_range(0, 3))
                             0: d[k] = 32'h7fffffff;
                             1: d[k] = 32'h80000000;
                             2: d[k] = '0;
                             default: d[k] = $urandom();
                         endcase
                9:       d[k] = 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
                default: d[k] = 32'(w + $signed($urandom_range(0, 1 << 21)) - (1 << 20));
            endcase
        end
        return d;
    endfunction

    initial
    begin
        node_in_t table_in [12];
        bit table_typed [12];
        node_out_t none;
        none = '0;
        relax_sym = -(64'sd1 <<< FRAC);
        relax_anti = -div_floor(16 * (64'sd1 <<< FRAC) + 7, 14);
        speed = 64'sd1 <<< FRAC;
        inv_speed = speed;
        ref_dens = speed;
        inv_ref = speed;

        foreach (table_typed[i])
            table_typed[i] = 1'b0;
        table_in[0] = '0;
        table_typed[0] = 1'b1;
        table_in[1] = {9{32'h7fffffff}};
        table_in[2] = {9{32'h80000000}};
        table_in[3] = {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                       32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
        table_in[4] = {9{32'hffffffff}};
        table_in[5] = {32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h01000000};
        table_in[6] = {32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h0};
        table_in[7] = {32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h0, 32'h0};
        table_in[8] = {32'h0, 32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h0};
        table_in[9] = {32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h0, 32'h0,
                       32'h0};
        table_in[10] = {32'h00071c72, 32'h00071c72, 32'h00071c72, 32'h00071c72,
                        32'h001c71c7, 32'h001c71c7, 32'h001c71c7, 32'h001c71c7, 32'h0071c71c};
        table_in[11] = {32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
                        32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555};

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, directed rows, then random nodes
        foreach (table_in[i])
            send_node(table_in[i], table_typed[i], none);
        repeat (150) send_node(random_node(), 1'b0, none);

        configure(64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff,
                  64'sh7fffffff, 64'sh7fffffff);
        foreach (table_in[i])
            send_node(table_in[i], 1'b0, none);
        repeat (140) send_node(random_node(), 1'b0, none);

        configure(-64'sh80000000, -64'sh80000000, -64'sh80000000, -64'sh80000000,
                  -64'sh80000000, -64'sh80000000);
        foreach (table_in[i])
            send_node(table_in[i], 1'b0, none);
        repeat (140) send_node(random_node(), 1'b0, none);

        // tau 1.25, speed 2, reference density 1
        configure(-13421773, -15000000, 64'sd2 <<< FRAC, 64'sd1 <<< (FRAC - 1),
                  64'sd1 <<< FRAC, 64'sd1 <<< FRAC);
        repeat (160) send_node(random_node(), 1'b0, none);

        configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        repeat (140) send_node(random_node(), 1'b0, none);

        configure(0, 0, 0, 0, 0, 0);
        repeat (100) send_node(random_node(), 1'b0, none);

        configure(-(64'sd1 <<< FRAC), -19173961, 64'sd1 <<< FRAC, 64'sd1 <<< FRAC,
                  64'sd3 <<< (FRAC - 1), 64'sd2 <<< (FRAC - 2));
        repeat (100) send_node(random_node(), 1'b0, none);

        drain();
        $display("%0d nodes sent, %0d results checked over %0d register settings",
                 nodes_sent, nodes_checked, phases + 1);
        $display("covered extreme and random rates, saturating inputs and ignored indexes");
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb failed");
        $finish;
    end

endmodule
